>>> rtl/ildd_pkg.sv
// Shared types, codes and the 4B/5B group table of the idle-lock descrambler and decoder.
package ildd_pkg;

  localparam int unsigned LFSR_W      = 11;
  localparam int unsigned WIN_W       = 10;
  localparam int unsigned GRP_W       = 5;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned ICL_W       = 7;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [3:0]         SEED_LEN       = 4'd11;
  localparam logic [LIMIT_W-1:0] HUNT_LIMIT_RST = 16'd16384;
  localparam logic [ICL_W-1:0]   IDLE_CHECK_RST = 7'd64;
  localparam logic [WIN_W-1:0]   START_PATTERN  = 10'h311;

  localparam logic [GRP_W-1:0] GRP_J    = 5'h18;
  localparam logic [GRP_W-1:0] GRP_H    = 5'h04;
  localparam logic [GRP_W-1:0] GRP_T    = 5'h0d;
  localparam logic [GRP_W-1:0] GRP_IDLE = 5'h1f;

  // register indexes on the configuration port
  localparam logic CFG_HUNT_LIMIT = 1'b0;
  localparam logic CFG_IDLE_CHECK = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic       skip;
    logic       high_next;
    logic [3:0] low_nibble;
  } dec_state_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } dec_result_t;

  function automatic logic [3:0] nibble_of_group(input logic [GRP_W-1:0] g);
    logic [3:0] n;
    case (g)
      5'h09:   n = 4'h1;
      5'h0a:   n = 4'h4;
      5'h0b:   n = 4'h5;
      5'h0e:   n = 4'h6;
      5'h0f:   n = 4'h7;
      5'h12:   n = 4'h8;
      5'h13:   n = 4'h9;
      5'h14:   n = 4'h2;
      5'h15:   n = 4'h3;
      5'h16:   n = 4'ha;
      5'h17:   n = 4'hb;
      5'h1a:   n = 4'hc;
      5'h1b:   n = 4'hd;
      5'h1c:   n = 4'he;
      5'h1d:   n = 4'hf;
      default: n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/ildd_group_dec.sv
// 5-bit group decoder: control groups, skip handling and low/high nibble pairing.
module ildd_group_dec
  import ildd_pkg::*;
(
  input  logic [GRP_W-1:0] group_i,
  input  dec_state_t       state_i,
  output dec_state_t       state_o,
  output dec_result_t      result_o
);

  logic [3:0] nib;

  assign nib = nibble_of_group(group_i);

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, kind: KIND_DATA, data: 8'h00};
    if (state_i.skip) begin
      state_o.skip = 1'b0;
    end else if (group_i == GRP_J) begin
      state_o.skip = 1'b1;
    end else if (group_i == GRP_H) begin
      result_o = '{valid: 1'b1, kind: KIND_ERROR, data: 8'h00};
    end else if (group_i == GRP_T) begin
      // the R group after T is swallowed
      state_o.skip = 1'b1;
      result_o     = '{valid: 1'b1, kind: KIND_END, data: 8'h00};
    end else if (group_i != GRP_IDLE) begin
      if (!state_i.high_next) begin
        state_o.low_nibble = nib;
        state_o.high_next  = 1'b1;
      end else begin
        state_o.high_next = 1'b0;
        result_o = '{valid: 1'b1, kind: KIND_DATA, data: {nib, state_i.low_nibble}};
      end
    end
  end

endmodule

>>> rtl/idle_lock_descrambler_4b5b_decoder_top.sv
// Top level: descrambler lock hunt, J/K start search and 4B/5B decode to bytes.
//
// Input stream: one recovered line bit per transaction in in_tdata[0] (1 = MLT-3
// transition). Output stream: out_tdata holds the byte, out_tuser the kind
// (data byte, frame end on /T/, transmit error on /H/).
// The block hunts for descrambler lock by seeding the 11-bit LFSR from inverted
// line bits and then requiring idle_check_len descrambled ones; on a mismatch it
// reseeds from the newest 11 bits. Past hunt_limit it halts and swallows all bits
// until reset. After lock it searches for J/K, then decodes 5-bit groups.
// Throughput: one bit per cycle while in_tready is high; all work for a bit is done
// in the cycle it is accepted, the result is registered at that edge and shows on
// out_tvalid in the next cycle.
// The output register decouples the sides: a new bit is taken while a result
// waits, as long as out_tready is high or the register is empty. A stalled
// receiver holds one result and, once that register is full, in_tready drops.
// cfg writes (index 0 hunt_limit, 1 idle_check_len) are always ready.
// Reset (rst_n low, synchronous) returns to hunting with cleared state,
// hunt_limit 16384 and idle_check_len 64.
module idle_lock_descrambler_4b5b_decoder_top
  import ildd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] line_bit, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_byte
  output logic [1:0]            out_tuser,  // [1:0] out_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_SEEK   = 2'd1,
    MODE_DECODE = 2'd2,
    MODE_HALT   = 2'd3
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [3:0]          seed_fill_r, seed_fill_nxt;
  logic [ICL_W-1:0]    idle_matches_r, idle_matches_nxt;
  logic [LIMIT_W-1:0]  bit_index_r, bit_index_nxt;
  logic [WIN_W-1:0]    start_window_r, start_window_nxt;
  logic [GRP_W-1:0]    code_shift_r, code_shift_nxt;
  logic [2:0]          code_cnt_r, code_cnt_nxt;
  dec_state_t          dec_r, dec_nxt, dec_upd;
  logic [LIMIT_W-1:0]  hunt_limit_r;
  logic [ICL_W-1:0]    idle_check_r;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [7:0]          out_byte_r;

  logic                in_accept;
  logic                b;
  logic                key;
  logic                d;
  logic [WIN_W-1:0]    win_shift;
  logic [GRP_W-1:0]    grp_shift;
  dec_result_t         dec_res;
  logic                res_valid;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign b         = in_tdata[0];
  assign key       = lfsr_r[8] ^ lfsr_r[10];
  assign d         = b ^ key;
  assign win_shift = {start_window_r[WIN_W-2:0], d};
  assign grp_shift = {code_shift_r[GRP_W-2:0], d};
  assign cfg_ready = 1'b1;

  ildd_group_dec u_group_dec (
    .group_i  (grp_shift),
    .state_i  (dec_r),
    .state_o  (dec_upd),
    .result_o (dec_res)
  );

  always_comb begin
    mode_nxt         = mode_r;
    lfsr_nxt         = lfsr_r;
    seed_fill_nxt    = seed_fill_r;
    idle_matches_nxt = idle_matches_r;
    bit_index_nxt    = bit_index_r;
    start_window_nxt = start_window_r;
    code_shift_nxt   = code_shift_r;
    code_cnt_nxt     = code_cnt_r;
    dec_nxt          = dec_r;
    res_valid        = 1'b0;
    if (in_accept) begin
      case (mode_r)
        MODE_HUNT: begin
          if (bit_index_r != '1) begin
            bit_index_nxt = bit_index_r + 1'b1;
          end
          if (seed_fill_r < SEED_LEN) begin
            if (hunt_limit_r == '0) begin
              mode_nxt = MODE_HALT;
            end else begin
              lfsr_nxt      = {lfsr_r[LFSR_W-2:0], ~b};
              seed_fill_nxt = seed_fill_r + 1'b1;
            end
          end else begin
            // a match leaves the shifted-in inverted bit equal to the key
            lfsr_nxt = {lfsr_r[LFSR_W-2:0], ~b};
            if (d) begin
              if (idle_matches_r != '1) begin
                idle_matches_nxt = idle_matches_r + 1'b1;
              end
              start_window_nxt = {start_window_r[WIN_W-2:0], 1'b1};
            end else begin
              idle_matches_nxt = '0;
              start_window_nxt = '0;
              if ((bit_index_r - LIMIT_W'(10)) >= hunt_limit_r) begin
                mode_nxt = MODE_HALT;
              end
            end
          end
          if (mode_nxt != MODE_HALT && seed_fill_nxt >= SEED_LEN &&
              idle_matches_nxt >= idle_check_r) begin
            mode_nxt = MODE_SEEK;
          end
        end
        MODE_SEEK: begin
          lfsr_nxt         = {lfsr_r[LFSR_W-2:0], key};
          start_window_nxt = win_shift;
          if (win_shift == START_PATTERN) begin
            mode_nxt       = MODE_DECODE;
            code_shift_nxt = '0;
            code_cnt_nxt   = '0;
          end
        end
        MODE_DECODE: begin
          lfsr_nxt       = {lfsr_r[LFSR_W-2:0], key};
          code_shift_nxt = grp_shift;
          if (code_cnt_r == 3'd4) begin
            code_cnt_nxt = '0;
            dec_nxt      = dec_upd;
            res_valid    = dec_res.valid;
          end else begin
            code_cnt_nxt = code_cnt_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_HUNT;
      lfsr_r         <= '0;
      seed_fill_r    <= '0;
      idle_matches_r <= '0;
      bit_index_r    <= '0;
      start_window_r <= '0;
      code_shift_r   <= '0;
      code_cnt_r     <= '0;
      dec_r          <= '0;
      hunt_limit_r   <= HUNT_LIMIT_RST;
      idle_check_r   <= IDLE_CHECK_RST;
      out_valid_r    <= 1'b0;
    end else begin
      mode_r         <= mode_nxt;
      lfsr_r         <= lfsr_nxt;
      seed_fill_r    <= seed_fill_nxt;
      idle_matches_r <= idle_matches_nxt;
      bit_index_r    <= bit_index_nxt;
      start_window_r <= start_window_nxt;
      code_shift_r   <= code_shift_nxt;
      code_cnt_r     <= code_cnt_nxt;
      dec_r          <= dec_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HUNT_LIMIT: hunt_limit_r <= cfg_data[LIMIT_W-1:0];
          CFG_IDLE_CHECK: idle_check_r <= cfg_data[ICL_W-1:0];
          default: begin
          end
        endcase
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind_r <= dec_res.kind;
      out_byte_r <= dec_res.data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HALT |=> mode_r == MODE_HALT)
    else $error("left halted mode without reset");

  a_result_only_decoding: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> mode_r == MODE_DECODE && code_cnt_r == 3'd4)
    else $error("result outside a group boundary");

  a_ctrl_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> out_tdata == 8'h00)
    else $error("control result carries nonzero byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !res_valid)
    else $error("pending result overwritten");

endmodule
